>>> src/escd_pkg.sv
package escd_pkg;

  // Code geometry
  localparam int CodeBits = 39;
  localparam int CheckBits = 7;
  localparam int NumRows = 7;
  localparam int MaxCand = 6;
  localparam int RegW = 39;
  localparam int MsgW = 32;
  localparam int PosW = 6;
  localparam int IdxW = 3;
  localparam int CntW = (MaxCand > 1) ? $clog2(MaxCand) : 1;

  // Front-to-back queue
  localparam int QDepth = 4;
  localparam int QPtrW = 2;
  localparam int QCntW = 3;

  typedef enum logic [1:0] {
    OutClean = 2'd0,
    OutFlip  = 2'd1,
    OutNone  = 2'd2
  } outcome_e;

  // One classified word waiting for the back end
  typedef struct packed {
    logic [CodeBits-1:0] word;
    logic                syn_zero;
    logic [CodeBits-1:0] match;
  } entry_t;

  typedef logic [RegW-1:0] row_t;

endpackage

>>> src/escd_front.sv
module escd_front import escd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxW-1:0]     cfg_idx_i,
  input  logic [RegW-1:0]     cfg_wdata_i,
  input  logic [RegW-1:0]     received_word_i,
  output entry_t              entry_o
);

  row_t rows_q [NumRows];

  // Parity-check row registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        rows_q[r] <= '0;
      end
    end else if (cfg_we_i && (int'(cfg_idx_i) < NumRows)) begin
      rows_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  logic [CodeBits-1:0]  word;
  logic [CheckBits-1:0] syn;
  logic [CheckBits-1:0] col [CodeBits];

  // Syndrome, one parity tree per row; row 0 feeds the top bit
  always_comb begin
    word = received_word_i[CodeBits-1:0];
    syn = '0;
    for (int r = 0; r < CheckBits; r++) begin
      syn[CheckBits-1-r] = ^(rows_q[r][CodeBits-1:0] & word);
    end
  end

  // Column compare for every codeword bit
  always_comb begin
    entry_o.word = word;
    entry_o.syn_zero = (syn == '0);
    for (int p = 0; p < CodeBits; p++) begin
      for (int r = 0; r < CheckBits; r++) begin
        col[p][CheckBits-1-r] = rows_q[r][p];
      end
      entry_o.match[p] = (col[p] == syn);
    end
  end

endmodule

>>> src/escd_queue.sv
module escd_queue import escd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_o
);

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;

  assign full_o = (count_q == QCntW'(QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q != QCntW'(QDepth)))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue underflow");
`endif

endmodule

>>> src/escd_back.sv
module escd_back import escd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  entry_t           head_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output logic [MsgW-1:0]  decoded_msg_o,
  output logic [PosW-1:0]  flipped_bit_o,
  output logic [1:0]       outcome_o,
  output logic             last_result_o
);

  logic                cur_valid_q, cur_valid_d;
  entry_t              cur_q, cur_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  logic                out_valid_q;
  logic [MsgW-1:0]     msg_q, msg_d;
  logic [PosW-1:0]     pos_q, pos_d;
  outcome_e            outc_q, outc_d;
  logic                last_q, last_d;

  logic [PosW-1:0]     top_pos;
  logic [CodeBits-1:0] bit_sel;
  logic [CodeBits-1:0] fixed_word;
  logic [CodeBits-1:0] rest;

  // Highest remaining match
  always_comb begin
    top_pos = '0;
    for (int i = 0; i < CodeBits; i++) begin
      if (cur_q.match[i]) begin
        top_pos = PosW'(i);
      end
    end
    bit_sel = CodeBits'(1) << top_pos;
    fixed_word = cur_q.word ^ bit_sel;
    rest = cur_q.match & ~bit_sel;
  end

  // Result for the current word
  always_comb begin
    if (cur_q.syn_zero) begin
      msg_d = cur_q.word[CheckBits +: MsgW];
      pos_d = '0;
      outc_d = OutClean;
      last_d = 1'b1;
    end else if (cur_q.match == '0) begin
      msg_d = cur_q.word[CheckBits +: MsgW];
      pos_d = '0;
      outc_d = OutNone;
      last_d = 1'b1;
    end else begin
      msg_d = fixed_word[CheckBits +: MsgW];
      pos_d = top_pos;
      outc_d = OutFlip;
      last_d = (rest == '0) || (cnt_q == CntW'(MaxCand - 1));
    end
  end

  // Load the next word when idle or on the last result of this one
  always_comb begin
    pop_o = head_valid_i && (!cur_valid_q || last_d);
    cur_valid_d = cur_valid_q && !last_d;
    cur_d = cur_q;
    cnt_d = cnt_q;
    if (cur_valid_q) begin
      cur_d.match = rest;
      cnt_d = cnt_q + 1'b1;
    end
    if (pop_o) begin
      cur_valid_d = 1'b1;
      cur_d = head_i;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= cur_valid_q;
      cnt_q <= cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cur_valid_q) begin
      msg_q <= msg_d;
      pos_q <= pos_d;
      outc_q <= outc_d;
      last_q <= last_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign decoded_msg_o = msg_q;
  assign flipped_bit_o = pos_q;
  assign outcome_o = outc_q;
  assign last_result_o = last_q;

`ifndef SYNTH
  a_clean_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (outc_q != OutFlip)) |-> (last_q && (pos_q == '0)))
    else $error("clean or no-candidate result not final");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && (cnt_q == CntW'(MaxCand - 1))) |=> !out_valid_q || last_q)
    else $error("candidate list exceeds cap");
`endif

endmodule

>>> src/ecc_syndrome_candidate_decoder_core.sv
// Channel   | Ports                                        | Transfer
// input     | start, busy, received_word_i                 | start && !busy at clk edge
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i             | cfg_we_i at clk edge
// result    | result_valid_o, decoded_msg_o,               | result_valid_o at clk edge
//           | flipped_bit_o, outcome_o, last_result_o      |
//
// A word is taken every cycle while busy is low; the front classifies it in the accept cycle.
// The back end emits one result per cycle while it holds a word; a word has
// 1 to 6 results, registered after the queue and the current-word register.
// A four-entry queue sits between front and back; busy is the queue full.
// Reset clears the check rows and all control state; results cannot stall.
module ecc_syndrome_candidate_decoder_core import escd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [RegW-1:0]  received_word_i,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_idx_i,
  input  logic [RegW-1:0]  cfg_wdata_i,
  output logic             result_valid_o,
  output logic [MsgW-1:0]  decoded_msg_o,
  output logic [PosW-1:0]  flipped_bit_o,
  output logic [1:0]       outcome_o,
  output logic             last_result_o
);

  entry_t entry;
  entry_t head;
  logic   full;
  logic   head_valid;
  logic   pop;

  assign busy = full;

  escd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .received_word_i (received_word_i),
    .entry_o         (entry)
  );

  escd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (start && !full),
    .push_data_i  (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  escd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .decoded_msg_o  (decoded_msg_o),
    .flipped_bit_o  (flipped_bit_o),
    .outcome_o      (outcome_o),
    .last_result_o  (last_result_o)
  );

endmodule
